@@ rtl/psvd_pkg.sv @@
// Shared types and constants for the program stream video demultiplexer.
package psvd_pkg;

  localparam logic [7:0] VIDEO_ID   = 8'hE0;
  localparam logic [7:0] SYSHDR_ID  = 8'hBB;
  localparam logic [7:0] MAP_ID     = 8'hBC;
  localparam logic [7:0] AUDIO_ID   = 8'hC0;
  localparam logic [7:0] PRIV_ID    = 8'hBD;
  localparam logic [7:0] STUFF_MASK = 8'h07;

  localparam logic [2:0] ST_END      = 3'd0;
  localparam logic [2:0] ST_AUDIO    = 3'd1;
  localparam logic [2:0] ST_UNKNOWN  = 3'd2;
  localparam logic [2:0] ST_BAD_PACK = 3'd3;
  localparam logic [2:0] ST_TRUNC    = 3'd4;
  localparam logic [2:0] ST_SHORT    = 3'd5;

  // One classified result as it travels from the parser to the output queue.
  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [23:0] len;
    logic [2:0]  status;
    logic        dropped;
  } psvd_res_t;

endpackage

@@ rtl/psvd_parser.sv @@
// Front part: parses stream bytes and classifies the results they cause.
module psvd_parser import psvd_pkg::*; #(
  parameter int LENGTH_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic [23:0] max_frame_bytes,
  output logic        res0_valid,
  output psvd_res_t   res0,
  output logic        res1_valid,
  output psvd_res_t   res1
);

  // Width of the limit comparison: wide enough for the count, the limit and a carry.
  localparam int CW = ((LENGTH_WIDTH > 24) ? LENGTH_WIDTH : 24) + 1;

  typedef enum logic [3:0] {
    PH_PACK, PH_PACK_STUFF, PH_CODE_FIRST, PH_CODE, PH_PES_HDR,
    PH_PES_STUFF, PH_PAYLOAD, PH_SKIP_LEN, PH_SKIP_BODY
  } phase_t;

  phase_t                  phase, phase_next;
  logic [3:0]              hidx, hidx_next;
  logic [31:0]             shift, shift_next;
  logic [15:0]             plen, plen_next;
  logic [7:0]              stuff, stuff_next;
  logic [15:0]             remain, remain_next;
  logic [LENGTH_WIDTH-1:0] emitted, emitted_next;
  logic                    drop, drop_next;
  logic                    anydrop, anydrop_next;
  logic                    stopped, stopped_next;
  logic [2:0]              scode, scode_next;
  logic                    emit;
  logic [2:0]              status;
  logic [16:0]             need;
  logic [15:0]             pay;
  logic [CW-1:0]           total;

  // Per-byte parser step.
  always_comb begin
    phase_next = phase; hidx_next = hidx; shift_next = shift; plen_next = plen;
    stuff_next = stuff; remain_next = remain; emitted_next = emitted;
    drop_next = drop; anydrop_next = anydrop; stopped_next = stopped;
    scode_next = scode; emit = 1'b0;
    need  = 17'd3 + {9'd0, in_byte};
    pay   = plen - need[15:0];
    total = CW'(emitted) + CW'(pay);
    if (!stopped) begin
      unique case (phase)
        PH_PACK: begin
          if (hidx >= 4'd13) begin
            stuff_next = in_byte & STUFF_MASK;
            hidx_next = '0; shift_next = '0;
            phase_next = ((in_byte & STUFF_MASK) != 8'd0) ? PH_PACK_STUFF : PH_CODE_FIRST;
          end else hidx_next = hidx + 4'd1;
        end
        PH_PACK_STUFF: begin
          stuff_next = stuff - 8'd1;
          if (stuff <= 8'd1) phase_next = PH_CODE_FIRST;
        end
        PH_CODE_FIRST, PH_CODE: begin
          shift_next = {shift[23:0], in_byte};
          hidx_next = hidx + 4'd1;
          if (hidx >= 4'd3) begin
            hidx_next = 4'd4;
            if (shift[23:0] != 24'h000001) begin
              stopped_next = 1'b1; scode_next = ST_UNKNOWN;
            end else if (in_byte == VIDEO_ID) phase_next = PH_PES_HDR;
            else if (in_byte == SYSHDR_ID || in_byte == MAP_ID) phase_next = PH_SKIP_LEN;
            else if (in_byte == AUDIO_ID || in_byte == PRIV_ID) begin
              stopped_next = 1'b1; scode_next = ST_AUDIO;
            end else begin
              stopped_next = 1'b1; scode_next = ST_UNKNOWN;
            end
          end
        end
        PH_PES_HDR: begin
          if (hidx == 4'd4) begin
            plen_next = {in_byte, 8'd0}; hidx_next = hidx + 4'd1;
          end else if (hidx == 4'd5) begin
            plen_next = plen | {8'd0, in_byte}; hidx_next = hidx + 4'd1;
          end else if (hidx >= 4'd8) begin
            stuff_next = in_byte;
            if ({1'b0, plen} < need) begin
              stopped_next = 1'b1; scode_next = ST_SHORT;
            end else begin
              remain_next = pay;
              drop_next = 1'b0;
              if (pay != 16'd0 && total >= CW'(max_frame_bytes)) begin
                drop_next = 1'b1; anydrop_next = 1'b1;
              end
              if (in_byte != 8'd0) phase_next = PH_PES_STUFF;
              else if (pay != 16'd0) phase_next = PH_PAYLOAD;
              else begin
                phase_next = PH_CODE; hidx_next = '0; shift_next = '0;
              end
            end
          end else hidx_next = hidx + 4'd1;
        end
        PH_PES_STUFF: begin
          stuff_next = stuff - 8'd1;
          if (stuff <= 8'd1) begin
            if (remain != 16'd0) phase_next = PH_PAYLOAD;
            else begin
              phase_next = PH_CODE; hidx_next = '0; shift_next = '0;
            end
          end
        end
        PH_PAYLOAD: begin
          if (!drop) begin
            emit = 1'b1; emitted_next = emitted + 1'b1;
          end
          remain_next = remain - 16'd1;
          if (remain <= 16'd1) begin
            phase_next = PH_CODE; hidx_next = '0; shift_next = '0;
          end
        end
        PH_SKIP_LEN: begin
          if (hidx == 4'd4) begin
            plen_next = {in_byte, 8'd0}; hidx_next = hidx + 4'd1;
          end else begin
            plen_next = plen | {8'd0, in_byte};
            remain_next = plen | {8'd0, in_byte};
            if ((plen | {8'd0, in_byte}) == 16'd0) begin
              phase_next = PH_CODE; hidx_next = '0; shift_next = '0;
            end else phase_next = PH_SKIP_BODY;
          end
        end
        PH_SKIP_BODY: begin
          remain_next = remain - 16'd1;
          if (remain <= 16'd1) begin
            phase_next = PH_CODE; hidx_next = '0; shift_next = '0;
          end
        end
        default: begin
          phase_next = PH_CODE; hidx_next = '0; shift_next = '0;
        end
      endcase
    end
  end

  // End-of-buffer status from the state after this byte.
  always_comb begin
    if (stopped_next) status = scode_next;
    else begin
      unique case (phase_next)
        PH_PACK, PH_PACK_STUFF, PH_CODE_FIRST: status = ST_BAD_PACK;
        PH_PES_HDR, PH_SKIP_LEN:               status = ST_SHORT;
        PH_PES_STUFF, PH_PAYLOAD, PH_SKIP_BODY: status = ST_TRUNC;
        default:                               status = ST_END;
      endcase
    end
  end

  // Results of the byte taken this cycle.
  always_comb begin
    res0_valid = take && emit;
    res0 = '{kind: 1'b0, data: in_byte, len: 24'd0, status: ST_END, dropped: 1'b0};
    res1_valid = take && in_last;
    res1 = '{kind: 1'b1, data: 8'd0, len: 24'(emitted_next), status: status,
             dropped: anydrop_next};
  end

  // Parser state; a last byte restarts the parse.
  always_ff @(posedge clk) begin
    if (rst || (take && in_last)) begin
      phase <= PH_PACK; hidx <= '0; shift <= '0; plen <= '0; stuff <= '0;
      remain <= '0; emitted <= '0; drop <= 1'b0; anydrop <= 1'b0;
      stopped <= 1'b0; scode <= ST_END;
    end else if (take) begin
      phase <= phase_next; hidx <= hidx_next; shift <= shift_next;
      plen <= plen_next; stuff <= stuff_next; remain <= remain_next;
      emitted <= emitted_next; drop <= drop_next; anydrop <= anydrop_next;
      stopped <= stopped_next; scode <= scode_next;
    end
  end

endmodule

@@ rtl/psvd_queue.sv @@
// Back part: a small result queue that feeds the output channel.
module psvd_queue import psvd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push0,
  input  psvd_res_t data0,
  input  logic      push1,
  input  psvd_res_t data1,
  output logic      space,
  output logic      out_valid,
  output psvd_res_t out_data,
  input  logic      pop
);

  psvd_res_t  mem [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count;
  logic [1:0] npush;
  logic       do_pop;

  assign do_pop    = pop && (count != 3'd0);
  assign npush     = {1'b0, push0} + {1'b0, push1};
  assign space     = (count - {2'b0, do_pop}) <= 3'd2;
  assign out_valid = count != 3'd0;
  assign out_data  = mem[rptr];

  // Storage writes; a second result goes behind the first.
  always_ff @(posedge clk) begin
    if (push0) mem[wptr] <= data0;
    if (push1) mem[push0 ? wptr + 2'd1 : wptr] <= data1;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0; rptr <= '0; count <= '0;
    end else begin
      wptr  <= wptr + npush;
      rptr  <= rptr + {1'b0, do_pop};
      count <= count + {1'b0, npush} - {2'b0, do_pop};
    end
  end

endmodule

@@ rtl/program_stream_video_demux.sv @@
// Top level of the program stream video demultiplexer.
//
//  Channel   Signals                                    Direction
//  input     in_valid in_ready in_byte in_last          in
//  output    out_valid out_ready out_kind out_byte
//            frame_length end_status payload_dropped    out
//  config    cfg_we cfg_data                            in
//
// One byte is parsed per cycle while the queue has space.
// A byte yields up to two results, which the four-entry queue drains at one
// per cycle while out_ready is high, so a stream whose bytes are mostly payload runs at one per cycle.
// Reset is synchronous and sets the size limit to 1048576.
// The input stalls only when the queue cannot take two more results.
module program_stream_video_demux import psvd_pkg::*; #(
  parameter int LENGTH_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic [23:0] frame_length,
  output logic [2:0]  end_status,
  output logic        payload_dropped,
  input  logic        cfg_we,
  input  logic [23:0] cfg_data
);

  logic [23:0] max_frame_bytes;
  logic        take, r0v, r1v, space;
  psvd_res_t   r0, r1, od;

  // Size limit register.
  always_ff @(posedge clk) begin
    if (rst) max_frame_bytes <= 24'd1048576;
    else if (cfg_we) max_frame_bytes <= cfg_data;
  end

  assign in_ready = space;
  assign take     = in_valid && space;

  psvd_parser #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_parser (
    .clk, .rst, .take, .in_byte, .in_last, .max_frame_bytes,
    .res0_valid(r0v), .res0(r0), .res1_valid(r1v), .res1(r1)
  );

  psvd_queue u_queue (
    .clk, .rst, .push0(r0v), .data0(r0), .push1(r1v), .data1(r1),
    .space, .out_valid, .out_data(od), .pop(out_ready)
  );

  assign out_kind        = od.kind;
  assign out_byte        = od.data;
  assign frame_length    = od.len;
  assign end_status      = od.status;
  assign payload_dropped = od.dropped;

endmodule

@@ tb/program_stream_video_demux_tb.sv @@
// Testbench for the program stream video demultiplexer: directed and random buffers.
`timescale 1ns / 100ps

module program_stream_video_demux_tb;
  import psvd_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  // Parser phases of the predictor.
  typedef enum logic [3:0] {
    P_PACK, P_PACK_STUFF, P_CODE_FIRST, P_CODE, P_PES_HDR, P_PES_STUFF,
    P_PAYLOAD, P_SKIP_LEN, P_SKIP_BODY
  } phase_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic [23:0] frame_length;
  logic [2:0]  end_status;
  logic        payload_dropped;
  logic        cfg_we;
  logic [23:0] cfg_data;

  program_stream_video_demux dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_byte(out_byte), .frame_length(frame_length), .end_status(end_status),
    .payload_dropped(payload_dropped), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Predictor state.
  logic [23:0] limit_bytes;
  phase_t      phase;
  int unsigned hdr_idx;
  logic [31:0] code_shift;
  logic [15:0] pkt_len;
  int unsigned stuff_cnt;
  int unsigned remain;
  logic [23:0] emitted;
  logic        drop_cur;
  logic        any_drop;
  logic        stopped;
  logic [2:0]  stop_status;

  psvd_res_t   expected_q[$];
  int          errors;
  int          cycles;
  int          stall_left;
  bit          hold_off;
  bit          quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run ends here if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("program_stream_video_demux_tb NOT OK");
      $finish;
    end
  end

  task automatic clear_parser();
    phase = P_PACK; hdr_idx = 0; code_shift = '0; pkt_len = '0; stuff_cnt = 0;
    remain = 0; emitted = '0; drop_cur = 1'b0; any_drop = 1'b0;
    stopped = 1'b0; stop_status = ST_END;
  endtask

  task automatic halt(input logic [2:0] code);
    stopped = 1'b1;
    stop_status = code;
  endtask

  task automatic enter_code();
    phase = P_CODE; hdr_idx = 0; code_shift = '0;
  endtask

  // Advances the predictor by one byte and queues what it yields.
  task automatic demux_byte(input logic [7:0] b, input logic last);
    psvd_res_t r;
    logic [2:0] st;
    if (!stopped) begin
      case (phase)
        P_PACK: begin
          if (hdr_idx >= 13) begin
            stuff_cnt = 32'(b & STUFF_MASK);
            hdr_idx = 0; code_shift = '0;
            phase = (stuff_cnt != 0) ? P_PACK_STUFF : P_CODE_FIRST;
          end else hdr_idx++;
        end
        P_PACK_STUFF: begin
          if (stuff_cnt > 0) stuff_cnt--;
          if (stuff_cnt == 0) phase = P_CODE_FIRST;
        end
        P_CODE_FIRST, P_CODE: begin
          code_shift = {code_shift[23:0], b};
          hdr_idx++;
          if (hdr_idx >= 4) begin
            if (code_shift[31:8] != 24'h000001) halt(ST_UNKNOWN);
            else if (code_shift[7:0] == VIDEO_ID) phase = P_PES_HDR;
            else if (code_shift[7:0] == SYSHDR_ID || code_shift[7:0] == MAP_ID)
              phase = P_SKIP_LEN;
            else if (code_shift[7:0] == AUDIO_ID || code_shift[7:0] == PRIV_ID)
              halt(ST_AUDIO);
            else halt(ST_UNKNOWN);
            hdr_idx = 4;
          end
        end
        P_PES_HDR: begin
          if (hdr_idx == 4) begin
            pkt_len = {b, 8'h00}; hdr_idx++;
          end else if (hdr_idx == 5) begin
            pkt_len[7:0] = b; hdr_idx++;
          end else if (hdr_idx >= 8) begin
            stuff_cnt = 32'(b);
            if (pkt_len < 3 + b) halt(ST_SHORT);
            else begin
              remain = pkt_len - 3 - b;
              drop_cur = 1'b0;
              if (remain > 0 && emitted + remain >= limit_bytes) begin
                drop_cur = 1'b1; any_drop = 1'b1;
              end
              if (stuff_cnt > 0) phase = P_PES_STUFF;
              else if (remain > 0) phase = P_PAYLOAD;
              else enter_code();
            end
          end else hdr_idx++;
        end
        P_PES_STUFF: begin
          if (stuff_cnt > 0) stuff_cnt--;
          if (stuff_cnt == 0) begin
            if (remain > 0) phase = P_PAYLOAD;
            else enter_code();
          end
        end
        P_PAYLOAD: begin
          if (!drop_cur) begin
            r = '0; r.data = b;
            expected_q.push_back(r);
            emitted = emitted + 24'd1;
          end
          if (remain > 0) remain--;
          if (remain == 0) enter_code();
        end
        P_SKIP_LEN: begin
          if (hdr_idx == 4) begin
            pkt_len = {b, 8'h00}; hdr_idx++;
          end else begin
            pkt_len[7:0] = b;
            remain = 32'(pkt_len);
            if (remain == 0) enter_code();
            else phase = P_SKIP_BODY;
          end
        end
        P_SKIP_BODY: begin
          if (remain > 0) remain--;
          if (remain == 0) enter_code();
        end
        default: enter_code();
      endcase
    end
    if (last) begin
      if (stopped) st = stop_status;
      else begin
        case (phase)
          P_PACK, P_PACK_STUFF, P_CODE_FIRST: st = ST_BAD_PACK;
          P_PES_HDR, P_SKIP_LEN: st = ST_SHORT;
          P_PES_STUFF, P_PAYLOAD, P_SKIP_BODY: st = ST_TRUNC;
          default: st = ST_END;
        endcase
      end
      r = '0; r.kind = 1'b1; r.len = emitted; r.status = st; r.dropped = any_drop;
      expected_q.push_back(r);
      clear_parser();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  // Random idle gap: mostly short, occasionally long.
  function automatic int gap_len();
    if (quiet) return 0;
    if ($urandom_range(0, 3) != 0) return 0;
    return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Sends one byte as one transaction; valid stays up between back-to-back bytes.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1; in_byte <= b; in_last <= last;
    demux_byte(b, last);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Output side: random stalls, a few long ones, and a long hold-off when asked.
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else if (quiet) out_ready <= 1'b1;
    else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 49) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(10, 40);
    end else out_ready <= ($urandom_range(0, 4) != 0);
  end

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    psvd_res_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result transaction");
        errors++;
      end else begin
        w = expected_q.pop_front();
        if (out_kind !== w.kind) report_mismatch("out_kind", 24'(out_kind), 24'(w.kind));
        if (out_byte !== w.data) report_mismatch("out_byte", 24'(out_byte), 24'(w.data));
        if (frame_length !== w.len) report_mismatch("frame_length", frame_length, w.len);
        if (end_status !== w.status)
          report_mismatch("end_status", 24'(end_status), 24'(w.status));
        if (payload_dropped !== w.dropped)
          report_mismatch("payload_dropped", 24'(payload_dropped), 24'(w.dropped));
      end
    end
  end

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [23:0] v);
    wait_idle();
    cfg_we <= 1'b1; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_bytes = v;
  endtask

  // Pack header with a chosen stuffing count.
  task automatic send_pack(input int stuff);
    for (int i = 0; i < 13; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte({5'($urandom_range(0, 31)), stuff[2:0]}, 1'b0);
    for (int i = 0; i < stuff; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic send_code(input logic [7:0] id, input logic last);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h01, 1'b0);
    send_byte(id, last);
  endtask

  // Video packet; cut > 0 makes the cut-th byte from the packet's end the last byte of the buffer.
  task automatic send_video(input int plen, input int stuff, input int cut, input bit last);
    int total;
    int k;
    logic [15:0] l;
    l = 16'(plen);
    total = 9 + plen - 3;
    k = 0;
    send_code(VIDEO_ID, 1'b0);
    send_byte(l[15:8], 1'b0); send_byte(l[7:0], 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(stuff[7:0], last && plen == stuff + 3 && cut == 0);
    k = 9;
    while (k < total) begin
      send_byte(8'($urandom_range(0, 255)),
                (last && k == total - 1) || (cut > 0 && k == total - cut));
      if (cut > 0 && k == total - cut) return;
      k++;
    end
  endtask

  task automatic send_skip(input logic [7:0] id, input int len, input bit last);
    logic [15:0] l;
    l = 16'(len);
    send_code(id, 1'b0);
    send_byte(l[15:8], 1'b0);
    send_byte(l[7:0], last && len == 0);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(0, 255)), last && i == len - 1);
  endtask

  task automatic test_directed();
    send_pack(0); send_video(8, 0, 0, 1'b1);
    send_pack(7); send_video(6, 2, 0, 1'b0); send_skip(SYSHDR_ID, 3, 1'b0);
    send_skip(MAP_ID, 0, 1'b0); send_code(AUDIO_ID, 1'b0); send_byte(8'hFF, 1'b1);
    send_pack(1); send_code(PRIV_ID, 1'b1);
    send_pack(0); send_code(8'h42, 1'b1);
    send_pack(2); send_byte(8'h00, 1'b1);
    send_byte(8'h55, 1'b1);
    send_pack(0); send_video(5, 0, 0, 1'b0); send_byte(8'h00, 1'b1);
    send_pack(0); send_video(20, 1, 4, 1'b0);
    send_pack(0); send_video(2, 0, 0, 1'b1);
    send_pack(0); send_video(12, 0, 0, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b1);
    send_pack(0); send_byte(8'h00, 1'b0); send_byte(8'h01, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'hE0, 1'b0); send_byte(8'h00, 1'b1);
    send_pack(0); send_skip(SYSHDR_ID, 10, 1'b0); send_byte(8'h01, 1'b1);
    send_pack(0); send_video(3, 0, 0, 1'b1);
  endtask

  // Size limit at the extremes and in between.
  task automatic test_limits();
    write_limit(24'd1);
    send_pack(0); send_video(10, 0, 0, 1'b1);
    write_limit(24'd12);
    send_pack(0); send_video(10, 0, 0, 1'b0); send_video(8, 0, 0, 1'b0);
    send_video(4, 0, 0, 1'b1);
    write_limit(24'hFFFFFF);
    send_pack(0); send_video(40, 0, 0, 1'b1);
  endtask

  task automatic random_buffer();
    int npk;
    int sel;
    npk = $urandom_range(1, 5);
    send_pack($urandom_range(0, 7));
    for (int p = 0; p < npk; p++) begin
      sel = $urandom_range(0, 19);
      if (sel < 12) send_video($urandom_range(3, 40), $urandom_range(0, 3), 0, p == npk - 1);
      else if (sel < 14) send_skip($urandom_range(0, 1) ? SYSHDR_ID : MAP_ID,
                                   $urandom_range(0, 12), p == npk - 1);
      else if (sel < 15) begin
        send_video($urandom_range(3, 30), $urandom_range(0, 3), $urandom_range(1, 8), 1'b0);
        return;
      end else if (sel < 16) begin
        send_code($urandom_range(0, 1) ? AUDIO_ID : PRIV_ID, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        return;
      end else if (sel < 17) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        return;
      end else if (sel < 18) begin
        send_code(VIDEO_ID, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        return;
      end else send_video($urandom_range(3, 12), 0, 0, p == npk - 1);
    end
  endtask

  task automatic test_random();
    for (int n = 0; n < 16; n++) begin
      if (n % 10 == 0)
        write_limit(24'($urandom_range(0, 1) ? $urandom_range(1, 120) : 24'h100000));
      random_buffer();
    end
    for (int n = 0; n < 12; n++) begin
      // Noise buffers use random byte values from the full range.
      for (int i = 0; i < 10; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Receiver holds off while payload keeps coming, so the queue fills.
  task automatic test_backpressure();
    write_limit(24'hFFFFFF);
    quiet = 1'b1;
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_pack(0); send_video(60, 0, 0, 1'b1);
      end
    join
    quiet = 1'b0;
  endtask

  initial begin
    rst = 1'b1; in_valid = 1'b0; in_byte = '0; in_last = 1'b0;
    cfg_we = 1'b0; cfg_data = '0; errors = 0; cycles = 0; hold_off = 1'b0; quiet = 1'b0;
    stall_left = 0;
    limit_bytes = 24'd1048576;
    clear_parser();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_limits();
    test_backpressure();
    test_random();
    wait_idle();
    if (errors == 0) $display("program_stream_video_demux_tb OK");
    else $display("program_stream_video_demux_tb NOT OK");
    $finish;
  end

endmodule
